FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthand for the relay engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define TTRE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication whose consequent is checked in the cycle after the antecedent.
`define TTRE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ttre_pkg.sv
// ----------------------------------------------------------------------------
// ttre_pkg
// Types, codes and constants shared by the threshold trigger relay engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttre_pkg;

    localparam int FUNC_W       = 2;
    localparam int SLOT_IDX_W   = 4;
    localparam int LOW_W        = 41;
    localparam int HIGH_W       = 38;
    localparam int SENSOR_IDX_W = 4;
    localparam int VALUE_W      = 13;
    localparam int INPUT_W      = 19;
    localparam int RELAY_W      = 16;
    localparam int ATOL_W       = 12;
    localparam int CTOL_W       = 10;
    localparam int DMASK_W      = 3;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam int SENSOR_COUNT = 10;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [ATOL_W-1:0]  ATOL_RESET  = 12'd50;
    localparam logic [CTOL_W-1:0]  CTOL_RESET  = 10'd5;
    localparam logic [DMASK_W-1:0] DMASK_RESET = 3'd0;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_ANALOG_TOL  = 2'd0;
    localparam logic [1:0] REG_CLIMATE_TOL = 2'd1;
    localparam logic [1:0] REG_DIGITAL_MSK = 2'd2;

    typedef enum logic [1:0] {
        FUNC_SCAN     = 2'd0,
        FUNC_WR_LOW   = 2'd1,
        FUNC_WR_HIGH  = 2'd2,
        FUNC_SAMPLE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_SCAN,
        OP_WR_LOW,
        OP_WR_HIGH,
        OP_SAMPLE,
        OP_SKIP
    } op_t;

    localparam logic [1:0] COND_ABOVE = 2'd0;
    localparam logic [1:0] COND_BELOW = 2'd1;
    localparam logic [1:0] COND_EQUAL = 2'd2;

    localparam logic [1:0] ACT_OFF    = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [RELAY_W-1:0]        target;
        logic                      target_mask;
        logic [1:0]                action;
        logic                      logic_or;
        logic                      combined;
        logic signed [VALUE_W-1:0] threshold;
        logic [1:0]                cond;
        logic [3:0]                source;
        logic                      enable;
    } rule_low_t;

    typedef struct packed {
        logic [INPUT_W-1:0] desired;
        logic [INPUT_W-1:0] mask;
    } rule_high_t;

    typedef struct packed {
        op_t                       op;
        logic [SLOT_IDX_W-1:0]     slot;
        logic [LOW_W-1:0]          word;
        logic [SENSOR_IDX_W-1:0]   sensor;
        logic signed [VALUE_W-1:0] value;
        logic [INPUT_W-1:0]        inputs;
    } cmd_t;

    typedef struct packed {
        logic [ATOL_W-1:0]  analog_tol;
        logic [CTOL_W-1:0]  climate_tol;
        logic [DMASK_W-1:0] digital_mask;
    } cfg_t;

endpackage

FILE: sv/ttre_if.sv
// ----------------------------------------------------------------------------
// ttre_if
// Valid/ready channels carrying request and response items of the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttre_req_if;
    import ttre_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [FUNC_W-1:0]              func;
    logic [SLOT_IDX_W-1:0]          rule_index;
    logic [LOW_W-1:0]               rule_word;
    logic [SENSOR_IDX_W-1:0]        sensor_index;
    logic signed [VALUE_W-1:0]      sensor_value;
    logic [INPUT_W-1:0]             digital_inputs;

    modport source (
        output valid, func, rule_index, rule_word, sensor_index, sensor_value,
               digital_inputs,
        input  ready
    );

    modport sink (
        input  valid, func, rule_index, rule_word, sensor_index, sensor_value,
               digital_inputs,
        output ready
    );
endinterface

interface ttre_rsp_if;
    import ttre_pkg::*;

    logic               valid;
    logic               ready;
    logic [RELAY_W-1:0] relay_outputs;
    logic [RELAY_W-1:0] fired_rules;

    modport source (
        output valid, relay_outputs, fired_rules,
        input  ready
    );

    modport sink (
        input  valid, relay_outputs, fired_rules,
        output ready
    );
endinterface

FILE: sv/ttre_front.sv
// ----------------------------------------------------------------------------
// ttre_front
// Accepts request transfers, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttre_front #(
    parameter int RULE_SLOTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    ttre_req_if.sink        req,
    output logic            cmd_vld,
    output ttre_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    import ttre_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    cmd_t              dec;
    logic              push;
    logic              pop;
    logic              slot_ok;
    logic              sensor_ok;

    assign slot_ok   = 32'(req.rule_index) < RULE_SLOTS;
    assign sensor_ok = 32'(req.sensor_index) < SENSOR_COUNT;

    // Out-of-range writes and samples still return a result, but touch nothing.
    always_comb
    begin
        dec.slot   = req.rule_index;
        dec.word   = req.rule_word;
        dec.sensor = req.sensor_index;
        dec.value  = req.sensor_value;
        dec.inputs = req.digital_inputs;
        unique case (func_t'(req.func))
            FUNC_SCAN:    dec.op = OP_SCAN;
            FUNC_WR_LOW:  dec.op = slot_ok ? OP_WR_LOW : OP_SKIP;
            FUNC_WR_HIGH: dec.op = slot_ok ? OP_WR_HIGH : OP_SKIP;
            FUNC_SAMPLE:  dec.op = sensor_ok ? OP_SAMPLE : OP_SKIP;
            default:      dec.op = OP_SKIP;
        endcase
    end

    assign req.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign pop       = cmd_pop && cmd_vld;
    assign cmd_vld   = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `TTRE_ASSERT(a_q_bound, clk, rst_n, cnt_reg <= QCNT_W'(QDEPTH), "queue count overflow")
    `TTRE_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not grow")
    `TTRE_ASSERT_NEXT(a_q_shrink, clk, rst_n, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "queue count did not shrink")

endmodule

FILE: sv/ttre_back.sv
// ----------------------------------------------------------------------------
// ttre_back
// Executes queued commands: rule and sensor writes, and the rule scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttre_back #(
    parameter int RULE_SLOTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ttre_pkg::cfg_t  cfg,
    input  logic            cmd_vld,
    input  ttre_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    ttre_rsp_if.source      rsp
);
    import ttre_pkg::*;

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

    // Rule memories; valid bits stand in for the all-zero reset contents.
    logic [LOW_W-1:0]  lo_mem [RULE_SLOTS];
    logic [HIGH_W-1:0] hi_mem [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] lo_vld_reg;
    logic [RULE_SLOTS-1:0] hi_vld_reg;
    logic [LOW_W-1:0]  lo_q_reg;
    logic [HIGH_W-1:0] hi_q_reg;
    logic              lo_qv_reg;
    logic              hi_qv_reg;

    logic signed [VALUE_W-1:0] sensor_reg [SENSOR_COUNT];

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  wr_addr;
    logic               ev_vld_reg;
    logic [SLOT_W-1:0]  ev_slot_reg;
    logic [INPUT_W-1:0] scan_in_reg;
    logic [RELAY_W-1:0] relay_reg;
    logic [RELAY_W-1:0] fired_reg;
    logic               rsp_vld_reg;
    logic [RELAY_W-1:0] rsp_relay_reg;
    logic [RELAY_W-1:0] rsp_fired_reg;

    logic out_free;
    logic scan_end;
    logic issue;
    logic load_rsp;

    rule_low_t                 lo;
    rule_high_t                hi;
    logic signed [VALUE_W-1:0] thr;
    logic signed [VALUE_W-1:0] val;
    logic signed [VALUE_W:0]   diff;
    logic [VALUE_W:0]          mag;
    logic [ATOL_W-1:0]         tol;
    logic                      src_ok;
    logic                      climate;
    logic [1:0]                sensor_k;
    logic [DMASK_W:0]          dmask_ext;
    logic                      cond_ok;
    logic [INPUT_W-1:0]        match;
    logic                      in_ok;
    logic                      hit;
    logic [RELAY_W-1:0]        sel;
    logic [RELAY_W-1:0]        relay_eval;

    assign rd_addr  = rd_cnt_reg[SLOT_W-1:0];
    assign wr_addr  = SLOT_W'(cmd.slot);
    assign out_free = !rsp_vld_reg || rsp.ready;
    assign scan_end = (rd_cnt_reg == CNT_W'(RULE_SLOTS)) && !ev_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_vld && out_free && (cmd.op == OP_SCAN))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop  = 1'b0;
        issue    = 1'b0;
        load_rsp = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop  = cmd_vld && out_free;
                load_rsp = cmd_pop && (cmd.op != OP_SCAN);
            end
            ST_SCAN:
            begin
                issue    = (rd_cnt_reg != CNT_W'(RULE_SLOTS));
                load_rsp = scan_end;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // Evaluation of the rule read in the previous cycle.
    always_comb
    begin
        lo        = lo_qv_reg ? rule_low_t'(lo_q_reg) : '0;
        hi        = hi_qv_reg ? rule_high_t'(hi_q_reg) : '0;
        thr       = lo.threshold;
        src_ok    = lo.source < 4'(SENSOR_COUNT);
        climate   = src_ok && (lo.source >= 4'd4);
        sensor_k  = (lo.source < 4'd7) ? 2'(lo.source - 4'd4) : 2'(lo.source - 4'd7);
        dmask_ext = {1'b0, cfg.digital_mask};
        val       = src_ok ? sensor_reg[lo.source] : '0;
        tol       = climate ? ATOL_W'(cfg.climate_tol) : cfg.analog_tol;
        diff      = {val[VALUE_W-1], val} - {thr[VALUE_W-1], thr};
        mag       = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : (VALUE_W+1)'(diff);

        unique case (lo.cond)
            COND_ABOVE: cond_ok = val > thr;
            COND_BELOW: cond_ok = val < thr;
            COND_EQUAL: cond_ok = mag < (VALUE_W+1)'(tol);
            default:    cond_ok = 1'b0;
        endcase
        if (!src_ok || (climate && dmask_ext[sensor_k]))
        begin
            cond_ok = 1'b0;
        end

        match = ~(hi.desired ^ scan_in_reg) & hi.mask;
        in_ok = lo.logic_or ? (match != '0) : (match == hi.mask);
        hit   = ev_vld_reg && lo.enable && cond_ok && (!lo.combined || in_ok);

        // A single relay number past the last relay shifts out to nothing.
        sel = lo.target_mask ? lo.target : (RELAY_W'(1) << lo.target);
        unique case (lo.action)
            ACT_OFF:    relay_eval = relay_reg & ~sel;
            ACT_ON:     relay_eval = relay_reg | sel;
            ACT_TOGGLE: relay_eval = relay_reg ^ sel;
            default:    relay_eval = relay_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.op == OP_WR_LOW))
        begin
            lo_mem[wr_addr] <= cmd.word;
        end
        if (cmd_pop && (cmd.op == OP_WR_HIGH))
        begin
            hi_mem[wr_addr] <= cmd.word[HIGH_W-1:0];
        end
        lo_q_reg <= lo_mem[rd_addr];
        hi_q_reg <= hi_mem[rd_addr];
        if (cmd_pop && (cmd.op == OP_SCAN))
        begin
            scan_in_reg <= cmd.inputs;
        end
        if (load_rsp)
        begin
            rsp_relay_reg <= relay_reg;
            rsp_fired_reg <= (state_reg == ST_SCAN) ? fired_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            lo_vld_reg  <= '0;
            hi_vld_reg  <= '0;
            lo_qv_reg   <= 1'b0;
            hi_qv_reg   <= 1'b0;
            rd_cnt_reg  <= '0;
            ev_vld_reg  <= 1'b0;
            ev_slot_reg <= '0;
            relay_reg   <= '0;
            fired_reg   <= '0;
            rsp_vld_reg <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                sensor_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            lo_qv_reg   <= lo_vld_reg[rd_addr];
            hi_qv_reg   <= hi_vld_reg[rd_addr];
            ev_vld_reg  <= issue;
            ev_slot_reg <= rd_addr;

            if (cmd_pop && (cmd.op == OP_WR_LOW))
            begin
                lo_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd_pop && (cmd.op == OP_WR_HIGH))
            begin
                hi_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd_pop && (cmd.op == OP_SAMPLE))
            begin
                sensor_reg[cmd.sensor] <= cmd.value;
            end

            if (cmd_pop && (cmd.op == OP_SCAN))
            begin
                rd_cnt_reg <= '0;
                fired_reg  <= '0;
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (hit)
                begin
                    fired_reg <= fired_reg | (RELAY_W'(1) << ev_slot_reg);
                    relay_reg <= relay_eval;
                end
            end

            if (load_rsp)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.relay_outputs = rsp_relay_reg;
    assign rsp.fired_rules   = rsp_fired_reg;

    `TTRE_ASSERT(a_eval_in_scan, clk, rst_n, ev_vld_reg |-> $past(state_reg == ST_SCAN), "rule evaluated outside a scan")
    `TTRE_ASSERT(a_scan_out_empty, clk, rst_n, (state_reg == ST_SCAN) |-> !rsp_vld_reg, "response pending during scan")
    `TTRE_ASSERT(a_pop_nonempty, clk, rst_n, cmd_pop |-> cmd_vld, "command popped from empty queue")

endmodule

FILE: sv/threshold_trigger_relay_engine.sv
// ----------------------------------------------------------------------------
// threshold_trigger_relay_engine
// Rule-driven relay controller with an APB register port and
// valid/ready request and response channels.
// ----------------------------------------------------------------------------
// Each request transfer yields exactly one response transfer carrying the
// relay states after that request and, for a scan, one bit per rule that
// fired. A request first lands in a two-entry command queue, so the request
// side keeps moving while the execute side works or its response waits.
// During a scan the rule memory, which has one read port, is walked one slot
// per cycle, each rule being compared against its sensor reading and applied
// to the relays in the cycle after its read, so a later rule sees what an
// earlier one did. The rule tables start cleared through per-slot valid
// bits, so there is no clearing pass after reset. Registers are to be
// written only while no request is in flight; the block itself does not
// enforce this.
`timescale 1ns / 1ps

module threshold_trigger_relay_engine #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttre_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttre_pkg::PDATA_W-1:0]  pwdata,
    output logic [ttre_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    ttre_req_if.sink                      req,
    ttre_rsp_if.source                    rsp
);
    import ttre_pkg::*;

    // Tolerances and the digital-type sensor mask.
    cfg_t           cfg_reg;
    logic           cfg_wr;
    logic [1:0]     reg_idx;
    logic           cmd_vld;
    cmd_t           cmd;
    logic           cmd_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_tol   <= ATOL_RESET;
            cfg_reg.climate_tol  <= CTOL_RESET;
            cfg_reg.digital_mask <= DMASK_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ANALOG_TOL:  cfg_reg.analog_tol   <= pwdata[ATOL_W-1:0];
                REG_CLIMATE_TOL: cfg_reg.climate_tol  <= pwdata[CTOL_W-1:0];
                REG_DIGITAL_MSK: cfg_reg.digital_mask <= pwdata[DMASK_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Reads of an unmapped address return zero.
    always_comb
    begin
        unique case (reg_idx)
            REG_ANALOG_TOL:  prdata = PDATA_W'(cfg_reg.analog_tol);
            REG_CLIMATE_TOL: prdata = PDATA_W'(cfg_reg.climate_tol);
            REG_DIGITAL_MSK: prdata = PDATA_W'(cfg_reg.digital_mask);
            default:         prdata = '0;
        endcase
    end

    // The front decodes each request transfer into a command and queues it.
    ttre_front #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cmd_vld (cmd_vld),
        .cmd     (cmd),
        .cmd_pop (cmd_pop)
    );

    // The back owns the rule tables, readings and relays, and the response.
    ttre_back #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cmd_vld (cmd_vld),
        .cmd     (cmd),
        .cmd_pop (cmd_pop),
        .rsp     (rsp)
    );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the threshold trigger relay engine. Requests are
// driven on the valid/ready request channel, and every response is checked
// against a cycle-free model of the rule table, the sensor readings and the
// relays. Directed rules and samples come first, then tolerance and sensor
// type settings, then random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ttre_pkg::*;

    localparam int RULE_SLOTS  = 16;
    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    // A scan walks every slot, and twice its length covers the command queue
    // as well.
    localparam int SETTLE_CYCLES = 2 * (RULE_SLOTS + 3);

    // Codes the package does not name: the spare condition never holds and
    // the spare action fires the rule without touching any relay.
    localparam logic [1:0] COND_NEVER = 2'd3;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct {
        logic [RELAY_W-1:0] relays;
        logic [RELAY_W-1:0] fired;
    } relay_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    ttre_req_if req_ch();
    ttre_rsp_if rsp_ch();

    threshold_trigger_relay_engine #(
        .RULE_SLOTS(RULE_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow of the engine: rule halves, sensor readings, relays and the
    // three registers. It is updated in request order when a request
    // transfer completes, so responses can be predicted without timing.
    // ------------------------------------------------------------------------
    rule_low_t                 rule_low_mem [RULE_SLOTS];
    rule_high_t                rule_high_mem[RULE_SLOTS];
    logic signed [VALUE_W-1:0] reading_mem  [SENSOR_COUNT];
    logic [RELAY_W-1:0]        relay_state;
    logic [ATOL_W-1:0]         analog_tol;
    logic [CTOL_W-1:0]         climate_tol;
    logic [DMASK_W-1:0]        digital_mask;

    relay_result_t expected_relay_results[$];
    relay_result_t oldest_result;

    int          error_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    function automatic void reset_relay_model();
        for (int i = 0; i < RULE_SLOTS; i++)
        begin
            rule_low_mem[i]  = '0;
            rule_high_mem[i] = '0;
        end
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            reading_mem[i] = '0;
        end
        relay_state  = '0;
        analog_tol   = ATOL_RESET;
        climate_tol  = CTOL_RESET;
        digital_mask = DMASK_RESET;
    endfunction

    // Sensor side of a rule. Analog channels use the analog tolerance, the
    // climate readings the one in tenths; a climate sensor marked digital
    // keeps both its temperature and humidity rules from ever holding.
    function automatic bit rule_condition_holds(rule_low_t r);
        int unsigned tol;
        int unsigned sensor;
        int          value;
        int          thr;
        int          diff;
        if (r.source >= SENSOR_COUNT)
            return 1'b0;
        if (r.source < 4)
        begin
            tol = analog_tol;
        end
        else
        begin
            sensor = (r.source < 7) ? r.source - 4 : r.source - 7;
            if (digital_mask[sensor])
                return 1'b0;
            tol = climate_tol;
        end
        value = reading_mem[r.source];
        thr   = $signed(r.threshold);
        case (r.cond)
            COND_ABOVE: return value > thr;
            COND_BELOW: return value < thr;
            COND_EQUAL:
            begin
                diff = value - thr;
                if (diff < 0)
                    diff = -diff;
                return diff < int'(tol);
            end
            default:    return 1'b0;
        endcase
    endfunction

    // Input side of a combined rule. An empty mask passes AND logic and
    // fails OR logic.
    function automatic bit rule_inputs_match(rule_low_t r, rule_high_t h,
                                             logic [INPUT_W-1:0] ins);
        logic [INPUT_W-1:0] hits;
        hits = ~(h.desired ^ ins) & h.mask;
        if (r.logic_or)
            return hits != '0;
        return hits == h.mask;
    endfunction

    function automatic void apply_rule_action(rule_low_t r);
        logic [RELAY_W-1:0] sel;
        if (r.target_mask)
            sel = r.target;
        else if (r.target >= RELAY_W)
            sel = '0;
        else
            sel = 16'd1 << r.target;
        case (r.action)
            ACT_OFF:    relay_state &= ~sel;
            ACT_ON:     relay_state |= sel;
            ACT_TOGGLE: relay_state ^= sel;
            default:    ;
        endcase
    endfunction

    // Advances the shadow by one request and returns its response. Rules
    // are walked in slot order so a later rule sees the relays as the
    // earlier ones left them.
    function automatic relay_result_t compute_relay_result(
        func_t f, logic [SLOT_IDX_W-1:0] slot, logic [LOW_W-1:0] word,
        logic [SENSOR_IDX_W-1:0] sidx, logic signed [VALUE_W-1:0] sval,
        logic [INPUT_W-1:0] ins);
        relay_result_t res;
        bit            hit;
        res.fired = '0;
        case (f)
            FUNC_WR_LOW:
            begin
                if (slot < RULE_SLOTS)
                    rule_low_mem[slot] = word;
            end
            FUNC_WR_HIGH:
            begin
                if (slot < RULE_SLOTS)
                    rule_high_mem[slot] = word[HIGH_W-1:0];
            end
            FUNC_SAMPLE:
            begin
                if (sidx < SENSOR_COUNT)
                    reading_mem[sidx] = sval;
            end
            default:
            begin
                for (int i = 0; i < RULE_SLOTS; i++)
                begin
                    if (rule_low_mem[i].enable)
                    begin
                        hit = rule_condition_holds(rule_low_mem[i]);
                        if (rule_low_mem[i].combined)
                            hit = hit && rule_inputs_match(rule_low_mem[i],
                                                           rule_high_mem[i], ins);
                        if (hit)
                        begin
                            if (i < RELAY_W)
                                res.fired[i] = 1'b1;
                            apply_rule_action(rule_low_mem[i]);
                        end
                    end
                end
            end
        endcase
        res.relays = relay_state;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Response side: the ready stall is redrawn every cycle, and every
    // response transfer is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_relay_results.size() == 0)
            begin
                $error("unexpected response: relay_outputs %h, fired_rules %h",
                       rsp_ch.relay_outputs, rsp_ch.fired_rules);
                error_count++;
            end
            else
            begin
                oldest_result = expected_relay_results.pop_front();
                if (rsp_ch.relay_outputs !== oldest_result.relays)
                begin
                    $error("relay_outputs: expected %h, got %h",
                           oldest_result.relays, rsp_ch.relay_outputs);
                    error_count++;
                end
                if (rsp_ch.fired_rules !== oldest_result.fired)
                begin
                    $error("fired_rules: expected %h, got %h",
                           oldest_result.fired, rsp_ch.fired_rules);
                    error_count++;
                end
            end
        end
    end

    // Hard stop in case a transfer never completes.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[threshold_trigger_relay_engine] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Each call starts at a clock edge, may idle first, then
    // holds the request until its transfer and records the prediction.
    // ------------------------------------------------------------------------
    task automatic send_item(func_t f, logic [SLOT_IDX_W-1:0] slot,
                             logic [LOW_W-1:0] word, logic [SENSOR_IDX_W-1:0] sidx,
                             logic signed [VALUE_W-1:0] sval,
                             logic [INPUT_W-1:0] ins);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.func           <= f;
        req_ch.rule_index     <= slot;
        req_ch.rule_word      <= word;
        req_ch.sensor_index   <= sidx;
        req_ch.sensor_value   <= sval;
        req_ch.digital_inputs <= ins;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_relay_results.push_back(
            compute_relay_result(f, slot, word, sidx, sval, ins));
    endtask

    // Fields that the operation does not use still carry random values.
    function automatic logic signed [VALUE_W-1:0] random_reading();
        return VALUE_W'(int'($urandom_range(5119)) - 1024);
    endfunction

    function automatic logic [LOW_W-1:0] random_word();
        return LOW_W'({$urandom, $urandom});
    endfunction

    task automatic scan_rules(logic [INPUT_W-1:0] ins);
        send_item(FUNC_SCAN, SLOT_IDX_W'($urandom), random_word(),
                  SENSOR_IDX_W'($urandom), random_reading(), ins);
    endtask

    task automatic write_rule(func_t f, logic [SLOT_IDX_W-1:0] slot,
                              logic [LOW_W-1:0] word);
        send_item(f, slot, word, SENSOR_IDX_W'($urandom), random_reading(),
                  INPUT_W'($urandom));
    endtask

    task automatic sample_sensor(logic [SENSOR_IDX_W-1:0] sidx, int value);
        send_item(FUNC_SAMPLE, SLOT_IDX_W'($urandom), random_word(), sidx,
                  VALUE_W'(value), INPUT_W'($urandom));
    endtask

    // Builds an enabled low rule word.
    function automatic logic [LOW_W-1:0] rule_low_word(
        logic [3:0] src, logic [1:0] cond, int thr, bit comb, bit lor,
        logic [1:0] act, bit tmask, logic [RELAY_W-1:0] target);
        rule_low_t r;
        r.enable      = 1'b1;
        r.source      = src;
        r.cond        = cond;
        r.threshold   = thr[VALUE_W-1:0];
        r.combined    = comb;
        r.logic_or    = lor;
        r.action      = act;
        r.target_mask = tmask;
        r.target      = target;
        return r;
    endfunction

    // Random rules lean toward sources in range and thresholds close to the
    // current reading, so that equal conditions and near misses both occur.
    function automatic logic [LOW_W-1:0] random_rule_low();
        logic [3:0]         src;
        logic [1:0]         cond;
        logic [1:0]         act;
        logic [RELAY_W-1:0] target;
        logic [LOW_W-1:0]   word;
        bit                 tmask;
        int                 thr;
        int                 span;
        src  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        cond = ($urandom_range(15) == 0) ? COND_NEVER : 2'($urandom_range(2));
        act  = ($urandom_range(11) == 0) ? ACT_NONE : 2'($urandom_range(2));
        if (src < SENSOR_COUNT && $urandom_range(1) == 1)
        begin
            span = ((src < 4) ? int'(analog_tol) : int'(climate_tol)) + 2;
            if (span > 200)
                span = 200;
            thr = reading_mem[src] + int'($urandom_range(2 * span)) - span;
        end
        else
        begin
            thr = int'($urandom);
        end
        tmask = 1'($urandom_range(1));
        if (tmask || $urandom_range(7) == 0)
            target = RELAY_W'($urandom);
        else
            target = RELAY_W'($urandom_range(15));
        word = rule_low_word(src, cond, thr, $urandom_range(99) < 40,
                             1'($urandom_range(1)), act, tmask, target);
        if ($urandom_range(9) == 0)
            word[0] = 1'b0;
        return word;
    endfunction

    task automatic send_random_item();
        int unsigned          pick;
        logic [INPUT_W-1:0]   mask;
        logic [SENSOR_IDX_W-1:0] sidx;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            scan_rules(INPUT_W'($urandom));
        end
        else if (pick < 55)
        begin
            write_rule(FUNC_WR_LOW, SLOT_IDX_W'($urandom), random_rule_low());
        end
        else if (pick < 68)
        begin
            // Sparse masks keep AND rules reachable with random inputs.
            mask = ($urandom_range(7) == 0) ? '0 : INPUT_W'($urandom & $urandom & $urandom);
            write_rule(FUNC_WR_HIGH, SLOT_IDX_W'($urandom),
                       {3'($urandom), INPUT_W'($urandom), mask});
        end
        else
        begin
            sidx = ($urandom_range(9) == 0) ? SENSOR_IDX_W'($urandom_range(15, 10))
                                            : SENSOR_IDX_W'($urandom_range(9));
            if ($urandom_range(9) == 0)
                sample_sensor(sidx, int'($urandom_range(5119)) - 1024);
            else if (sidx < 4)
                sample_sensor(sidx, int'($urandom_range(4095)));
            else
                sample_sensor(sidx, int'($urandom_range(2024)) - 1024);
        end
    endtask

    task automatic run_random_items(int count);
        for (int i = 0; i < count; i++)
            send_random_item();
    endtask

    // Drops the request valid and waits for every outstanding response.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (expected_relay_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port. Every call starts at a clock edge with the engine idle.
    // ------------------------------------------------------------------------
    task automatic verify_register(logic [1:0] idx);
        logic [PDATA_W-1:0] want;
        case (idx)
            REG_ANALOG_TOL:  want = PDATA_W'(analog_tol);
            REG_CLIMATE_TOL: want = PDATA_W'(climate_tol);
            default:         want = PDATA_W'(digital_mask);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata of register %0d: expected %h, got %h", idx, want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // An idle phase with psel low closes the transfer before the next one starts.
        @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ANALOG_TOL:  analog_tol   = value[ATOL_W-1:0];
            REG_CLIMATE_TOL: climate_tol  = value[CTOL_W-1:0];
            default:         digital_mask = value[DMASK_W-1:0];
        endcase
        // The read that follows starts its own setup phase in this step.
        verify_register(idx);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of the registers, and a scan over an all-disabled table.
    task automatic test_reset_defaults();
        verify_register(REG_ANALOG_TOL);
        verify_register(REG_CLIMATE_TOL);
        verify_register(REG_DIGITAL_MSK);
        scan_rules('1);
    endtask

    // Hand-built rules for the corner cases: field extremes, every
    // condition and action, sources and relay numbers out of range, empty
    // masks under AND and OR logic, and spare bits in the high word.
    task automatic test_special_cases();
        sample_sensor(0, 4095);
        sample_sensor(4, -1024);
        sample_sensor(7, 456);
        sample_sensor(13, 1234);    // index out of range, ignored
        write_rule(FUNC_WR_LOW, 0,
                   rule_low_word(0, COND_ABOVE, 100, 0, 0, ACT_ON, 0, 16'd3));
        // Distance 49 is inside the default analog tolerance of 50.
        write_rule(FUNC_WR_LOW, 1,
                   rule_low_word(0, COND_EQUAL, 4046, 0, 0, ACT_TOGGLE, 1, 16'hFFFF));
        write_rule(FUNC_WR_LOW, 2,
                   rule_low_word(12, COND_ABOVE, -4096, 0, 0, ACT_ON, 0, 16'd0));
        write_rule(FUNC_WR_LOW, 3,
                   rule_low_word(0, COND_NEVER, -4096, 0, 0, ACT_ON, 0, 16'd1));
        // Empty input mask: AND passes and the spare action changes nothing.
        write_rule(FUNC_WR_LOW, 4,
                   rule_low_word(4, COND_BELOW, 0, 1, 0, ACT_NONE, 0, 16'd2));
        // Empty input mask under OR logic never passes.
        write_rule(FUNC_WR_LOW, 5,
                   rule_low_word(7, COND_ABOVE, 0, 1, 1, ACT_ON, 0, 16'd5));
        // Fires on a relay number past the last relay.
        write_rule(FUNC_WR_LOW, 6,
                   rule_low_word(4, COND_EQUAL, -1020, 0, 0, ACT_ON, 0, 16'd20));
        write_rule(FUNC_WR_HIGH, 15, {3'b111, 19'h55555, 19'h0F0F0});
        write_rule(FUNC_WR_LOW, 15,
                   rule_low_word(9, COND_BELOW, 1, 1, 0, ACT_ON, 1, 16'h8001));
        scan_rules(19'h55555);
        scan_rules(19'h2AAAA);
        write_rule(FUNC_WR_HIGH, 5, {3'b000, 19'h40000, 19'h40000});
        scan_rules(19'h40000);
        write_rule(FUNC_WR_LOW, 7,
                   rule_low_word(3, COND_BELOW, 1, 0, 0, ACT_OFF, 1, 16'hFFFF));
        scan_rules('0);
        write_rule(FUNC_WR_LOW, 0, '0);
        write_rule(FUNC_WR_LOW, 8,
                   rule_low_word(5, COND_EQUAL, 0, 0, 0, ACT_TOGGLE, 0, 16'd15));
        scan_rules('1);
        wait_for_results();
    endtask

    // Tolerances and sensor types at both ends, random settings, then back to the
    // reset settings, with random traffic under each.
    task automatic test_register_settings();
        int atol;
        int ctol;
        int dmask;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0:
                begin
                    atol = 0; ctol = 0; dmask = 0;
                end
                1:
                begin
                    atol = 4095; ctol = 1000; dmask = 7;
                end
                5:
                begin
                    atol = ATOL_RESET; ctol = CTOL_RESET; dmask = DMASK_RESET;
                end
                default:
                begin
                    atol  = $urandom_range(4095);
                    ctol  = $urandom_range(1000);
                    dmask = $urandom_range(7);
                end
            endcase
            write_register(REG_ANALOG_TOL, atol);
            write_register(REG_CLIMATE_TOL, ctol);
            write_register(REG_DIGITAL_MSK, dmask);
            run_random_items(40);
            wait_for_results();
        end
    endtask

    // Random traffic: clean flow, sender gaps, receiver stalls, then both.
    task automatic test_random_traffic();
        int unsigned idle_plan [4] = '{0, 69, 0, 32};
        int unsigned stall_plan[4] = '{0, 0, 69, 32};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            run_random_items(350);
            wait_for_results();
        end
    endtask

    initial
    begin
        reset_relay_model();
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= FUNC_SCAN;
        req_ch.rule_index     <= '0;
        req_ch.rule_word      <= '0;
        req_ch.sensor_index   <= '0;
        req_ch.sensor_value   <= '0;
        req_ch.digital_inputs <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_register_settings();
        test_random_traffic();

        // All responses are in; leave room for any stray extra one.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[threshold_trigger_relay_engine] OK");
        else
            $display("[threshold_trigger_relay_engine] ERROR");
        $finish;
    end

endmodule
